>>> hdl/lzbd_pkg.sv
`default_nettype none
package lzbd_pkg;
  localparam int WindowBytesDef = 4096;
  localparam int HeaderBytesDef = 14;
  localparam int OutLanesDef = 8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_count;
    logic        out_last;
    logic        out_done;
  } out_word_t;

  // Work handed from the front (bit decoder) to the back (history / packer).
  localparam logic [1:0] CMD_LIT  = 2'd0;
  localparam logic [1:0] CMD_COPY = 2'd1;
  localparam logic [1:0] CMD_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  lit;
    logic [12:0] off;
    logic [8:0]  len;
    logic        done;
  } cmd_t;

  // Decode phases.
  localparam logic [4:0] PH_HEADER = 5'd0;
  localparam logic [4:0] PH_TOP    = 5'd1;
  localparam logic [4:0] PH_LIT    = 5'd2;
  localparam logic [4:0] PH_C1     = 5'd3;
  localparam logic [4:0] PH_C2     = 5'd4;
  localparam logic [4:0] PH_C3     = 5'd5;
  localparam logic [4:0] PH_C4     = 5'd6;
  localparam logic [4:0] PH_COUNT  = 5'd7;
  localparam logic [4:0] PH_RUN    = 5'd8;
  localparam logic [4:0] PH_D      = 5'd9;
  localparam logic [4:0] PH_E      = 5'd10;
  localparam logic [4:0] PH_EXT    = 5'd11;
  localparam logic [4:0] PH_EXIT   = 5'd12;
  localparam logic [4:0] PH_DH     = 5'd13;
  localparam logic [4:0] PH_DP     = 5'd14;
  localparam logic [4:0] PH_DM     = 5'd15;
  localparam logic [4:0] PH_DX     = 5'd16;
  localparam logic [4:0] PH_DTERM  = 5'd17;
  localparam logic [4:0] PH_DT     = 5'd18;
  localparam logic [4:0] PH_LOW    = 5'd19;
  localparam logic [4:0] PH_DONE   = 5'd20;
endpackage
`default_nettype wire

>>> hdl/lzbd_front.sv
`default_nettype none
// Bit-flag decoder: consumes one input word, walks flag bits one per cycle,
// issues one command per cycle at most.
module lzbd_front #(
  parameter int HeaderBytes = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lzbd_pkg::in_word_t in_word,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output lzbd_pkg::cmd_t         cmd,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready
);
  import lzbd_pkg::*;

  logic       busy;
  logic [7:0] byte_val;
  logic       byte_ready;
  logic       was_done;
  logic [4:0] phase;
  logic [8:0] flag_bits;
  logic [3:0] header_count;
  logic [8:0] match_length;
  logic [3:0] distance_high;
  logic [6:0] literal_left;
  logic       stream_done;

  logic [4:0] phase_next;
  logic [8:0] flag_next;
  logic [3:0] hc_next;
  logic [8:0] ml_next;
  logic [3:0] dh_next;
  logic [6:0] ll_next;
  logic       sd_next;
  logic       br_next;
  logic       stop;
  logic       issue;
  cmd_t       c;
  logic [9:0] s;
  logic       bit_ok;
  logic       b;
  logic [8:0] fb_bit;
  logic [8:0] ml_c4;

  assign in_ready = !busy;

  always_comb begin
    s = {flag_bits, 1'b0};
    fb_bit = flag_bits;
    bit_ok = 1'b1;
    b = 1'b0;
    if (s[7:0] != 8'd0) begin
      fb_bit = {1'b0, s[7:0]};
      b = s[8];
    end else if (byte_ready) begin
      fb_bit = {byte_val, 1'b1};
      b = byte_val[7];
    end else begin
      bit_ok = 1'b0;
    end
  end

  assign ml_c4 = 9'((match_length << 1) - 9'd2 + {8'd0, b});

  always_comb begin
    phase_next = phase;
    flag_next = flag_bits;
    hc_next = header_count;
    ml_next = match_length;
    dh_next = distance_high;
    ll_next = literal_left;
    sd_next = stream_done;
    br_next = byte_ready;
    stop = 1'b0;
    issue = 1'b0;
    c = '0;
    c.cmd = CMD_LIT;
    c.lit = byte_val;
    c.off = 13'({distance_high, byte_val}) + 13'd1;
    c.len = match_length;
    unique case (phase)
      PH_HEADER, PH_LIT, PH_RUN, PH_EXT, PH_LOW: begin
        if (!byte_ready) stop = 1'b1;
        else begin
          br_next = 1'b0;
          if (phase == PH_HEADER) begin
            if (header_count < 4'(HeaderBytes)) hc_next = header_count + 4'd1;
            else begin
              flag_next = 9'({byte_val, 2'b10});
              phase_next = PH_TOP;
            end
          end else if (phase == PH_LIT) begin
            issue = 1'b1;
            phase_next = PH_TOP;
          end else if (phase == PH_RUN) begin
            issue = 1'b1;
            if (literal_left != 7'd0) ll_next = literal_left - 7'd1;
            if (literal_left <= 7'd1) phase_next = PH_TOP;
          end else if (phase == PH_EXT) begin
            if (byte_val != 8'd0) begin
              ml_next = {1'b0, byte_val} + 9'd8;
              phase_next = PH_DH;
            end else phase_next = PH_EXIT;
          end else begin
            issue = 1'b1;
            c.cmd = CMD_COPY;
            phase_next = PH_TOP;
          end
        end
      end
      PH_DONE: stop = 1'b1;
      default: begin
        if (!bit_ok) stop = 1'b1;
        else begin
          flag_next = fb_bit;
          if (s[7:0] == 8'd0) br_next = 1'b0;
          unique case (phase)
            PH_TOP: phase_next = b ? PH_C1 : PH_LIT;
            PH_C1:  phase_next = b ? PH_D : PH_C2;
            PH_C2: begin
              ml_next = 9'd4 + {8'd0, b};
              phase_next = PH_C3;
            end
            PH_C3:  phase_next = b ? PH_C4 : PH_DH;
            PH_C4: begin
              ml_next = ml_c4;
              if (ml_c4 == 9'd9) begin
                dh_next = 4'd0;
                ll_next = 7'd4;
                phase_next = PH_COUNT;
              end else phase_next = PH_DH;
            end
            PH_COUNT: begin
              dh_next = {distance_high[2:0], b};
              if (literal_left <= 7'd1) begin
                ll_next = 7'({3'd0, dh_next} + 7'd3) << 2;
                phase_next = PH_RUN;
              end else ll_next = literal_left - 7'd1;
            end
            PH_D: begin
              if (!b) begin
                ml_next = 9'd2;
                dh_next = 4'd0;
                phase_next = PH_LOW;
              end else phase_next = PH_E;
            end
            PH_E: begin
              if (!b) begin
                ml_next = 9'd3;
                phase_next = PH_DH;
              end else phase_next = PH_EXT;
            end
            PH_EXIT: begin
              if (b) phase_next = PH_TOP;
              else begin
                sd_next = 1'b1;
                phase_next = PH_DONE;
              end
            end
            PH_DH: begin
              if (!b) begin
                dh_next = 4'd0;
                phase_next = PH_LOW;
              end else phase_next = PH_DP;
            end
            PH_DP: begin
              dh_next = {3'd0, b};
              phase_next = PH_DM;
            end
            PH_DM: begin
              if (b) phase_next = PH_DX;
              else if (distance_high != 4'd0) phase_next = PH_LOW;
              else begin
                dh_next = 4'd1;
                phase_next = PH_DT;
              end
            end
            PH_DX: begin
              dh_next = 4'(4'd4 | {distance_high[2:0], b});
              phase_next = PH_DTERM;
            end
            PH_DTERM: phase_next = b ? PH_LOW : PH_DT;
            PH_DT: begin
              dh_next = {distance_high[2:0], b};
              phase_next = PH_LOW;
            end
            default: phase_next = PH_TOP;
          endcase
        end
      end
    endcase
    if (stop) begin
      issue = 1'b1;
      c.cmd = CMD_NONE;
      c.done = stream_done && !was_done;
    end
  end

  // A stop is sent as a NONE word only to close off the item's output.
  assign cmd = c;
  assign cmd_valid = busy && issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= PH_HEADER;
      flag_bits <= '0;
      header_count <= '0;
      match_length <= '0;
      distance_high <= '0;
      literal_left <= '0;
      stream_done <= 1'b0;
      byte_ready <= 1'b0;
      was_done <= 1'b0;
      byte_val <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        byte_val <= in_word.in_byte;
        byte_ready <= 1'b1;
        if (in_word.packet_start) begin
          phase <= PH_HEADER;
          flag_bits <= '0;
          header_count <= '0;
          match_length <= '0;
          distance_high <= '0;
          literal_left <= '0;
          stream_done <= 1'b0;
          was_done <= 1'b0;
        end else was_done <= stream_done;
      end
    end else if (!issue || cmd_ready) begin
      if (stop) busy <= 1'b0;
      else begin
        phase <= phase_next;
        flag_bits <= flag_next;
        header_count <= hc_next;
        match_length <= ml_next;
        distance_high <= dh_next;
        literal_left <= ll_next;
        stream_done <= sd_next;
        byte_ready <= br_next;
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/lzbd_queue.sv
`default_nettype none
// Two-entry command queue between decoder and back end.
module lzbd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lzbd_pkg::cmd_t wr_data,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  output lzbd_pkg::cmd_t      rd_data,
  output logic                rd_valid,
  input  wire logic           rd_ready
);
  import lzbd_pkg::*;
  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      cnt <= 2'(cnt + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready});
    end
  end
endmodule
`default_nettype wire

>>> hdl/lzbd_back.sv
`default_nettype none
// History memory, copy engine and byte packer; a copy reads each byte, then writes it.
module lzbd_back #(
  parameter int WindowBytes = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           ptr_clr,
  input  wire lzbd_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  output lzbd_pkg::out_word_t out_word,
  output logic                out_valid,
  input  wire logic           out_ready
);
  import lzbd_pkg::*;
  localparam int AW = $clog2(WindowBytes);

  logic [7:0]    hist [WindowBytes];
  logic [AW-1:0] wptr;
  logic [AW-1:0] src;
  logic [8:0]    left;
  logic          copying;
  logic          rd_pend;
  logic [7:0]    rd_q;
  logic [63:0]   pack;
  logic [3:0]    pcnt;
  logic          wr_en;
  logic [7:0]    wr_byte;
  logic          rd_en;
  logic          flush;
  logic          o_last;
  logic          o_done;

  // Packer emits when full or on item end; output register must be free.
  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Copy: read cycle then write cycle per byte (overlap safe).
  always_comb begin
    wr_en = 1'b0;
    wr_byte = cmd.lit;
    rd_en = 1'b0;
    flush = 1'b0;
    o_last = 1'b0;
    o_done = 1'b0;
    cmd_ready = 1'b0;
    if (pcnt == 4'd8) begin
      // hold a full word until the next command shows whether it ends the item
      if (copying) flush = out_free;
      else if (cmd_valid) begin
        flush = out_free;
        if (cmd.cmd == CMD_NONE) begin
          cmd_ready = out_free;
          o_last = 1'b1;
          o_done = cmd.done;
        end
      end
    end else if (copying) begin
      if (rd_pend) begin
        wr_en = 1'b1;
        wr_byte = rd_q;
      end else rd_en = 1'b1;
    end else if (cmd_valid) begin
      unique case (cmd.cmd)
        CMD_LIT: begin
          wr_en = 1'b1;
          cmd_ready = 1'b1;
        end
        CMD_COPY: cmd_ready = 1'b1;
        default: begin
          if (out_free) begin
            cmd_ready = 1'b1;
            flush = (pcnt != 4'd0) || cmd.done;
            o_last = 1'b1;
            o_done = cmd.done;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) hist[wptr] <= wr_byte;
    if (rd_en) rd_q <= hist[src];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      copying <= 1'b0;
      rd_pend <= 1'b0;
      pcnt <= '0;
      out_valid <= 1'b0;
      left <= '0;
      src <= '0;
      out_word <= '0;
      pack <= '0;
    end else begin
      if (flush) begin
        out_valid <= 1'b1;
        out_word.out_data <= pack;
        out_word.out_count <= pcnt;
        out_word.out_last <= o_last;
        out_word.out_done <= o_done;
        pcnt <= '0;
        pack <= '0;
      end else if (out_valid && out_ready) out_valid <= 1'b0;
      if (ptr_clr) wptr <= '0;
      else if (wr_en) wptr <= wptr + 1'b1;
      if (wr_en) begin
        pack[pcnt[2:0]*8 +: 8] <= wr_byte;
        pcnt <= pcnt + 4'd1;
      end
      if (rd_en) rd_pend <= 1'b1;
      if (copying && rd_pend && wr_en) begin
        rd_pend <= 1'b0;
        src <= src + 1'b1;
        left <= left - 9'd1;
        if (left == 9'd1) copying <= 1'b0;
      end
      if (cmd_valid && cmd_ready && cmd.cmd == CMD_COPY) begin
        copying <= 1'b1;
        left <= cmd.len;
        src <= wptr - AW'(cmd.off);
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/lz77_bitflag_decompressor.sv
`default_nettype none
// The front holds a word through its decode steps and one closing step before it
// takes the next; in the back end a literal byte is written directly, a match byte
// is read from history and then written, and each full word adds a flush step; the
// longest match is 263 bytes.
// Input: one word at a time; the queue stalls the front when full, as while the back copies.
// Reset: rst clears decode state and queue; history is not cleared.
module lz77_bitflag_decompressor #(
  parameter int WindowBytes = lzbd_pkg::WindowBytesDef,
  parameter int HeaderBytes = lzbd_pkg::HeaderBytesDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lzbd_pkg::in_word_t  in_word,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output lzbd_pkg::out_word_t      out_word,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  import lzbd_pkg::*;

  cmd_t f_cmd;
  logic f_valid;
  logic f_ready;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;
  logic ptr_clr;
  logic front_ready;

  // Packet start resets the write pointer; a packet-start word is held until
  // the queue and the front have no command pending.
  logic drained;
  assign drained = !q_valid && !f_valid;
  assign in_ready = front_ready && (!in_word.packet_start || drained);
  assign ptr_clr = in_valid && in_ready && in_word.packet_start;

  lzbd_front #(.HeaderBytes(HeaderBytes)) u_front (
    .clk, .rst, .in_word, .in_valid(in_valid && in_ready), .in_ready(front_ready),
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  lzbd_queue u_queue (
    .clk, .rst, .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  lzbd_back #(.WindowBytes(WindowBytes)) u_back (
    .clk, .rst, .ptr_clr, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .out_word, .out_valid, .out_ready
  );
endmodule
`default_nettype wire

>>> hdl/lzbd_checker.sv
`default_nettype none
module lzbd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire lzbd_pkg::out_word_t out_word
);
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.out_count <= 4'd8) else $error("count");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_count == 4'd0 |-> out_word.out_done && out_word.out_last)
    else $error("empty");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_word)) else $error("hold");
endmodule
bind lz77_bitflag_decompressor lzbd_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_word
);
`default_nettype wire
